FILE: rtl/fixed_point_fully_connected_unit_macros.svh
// Assertion macros used by the fully connected unit top level.
`ifndef FIXED_POINT_FULLY_CONNECTED_UNIT_MACROS_SVH
`define FIXED_POINT_FULLY_CONNECTED_UNIT_MACROS_SVH

`ifndef SYNTH

`define FCU_CHECK(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("fcu check failed");

`define FCU_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fcu implication failed");

`define FCU_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fcu next-cycle check failed");

`else

`define FCU_CHECK(label, expr)

`define FCU_IMPLY(label, ante, cons)

`define FCU_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/fcu_pkg.sv
// Types and constants of the fixed-point fully connected unit.
package fcu_pkg;

    localparam int CMD_W    = 2;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 10;
    localparam int VAL_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int OCNT_W   = 7;
    localparam int FRAC_W   = 5;
    localparam int PROD_W   = 32;

    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS = 1'd1;

    localparam logic [OCNT_W-1:0] OUT_COUNT_RST = 7'd64;
    localparam logic [FRAC_W-1:0] FRAC_BITS_RST = 5'd8;

    typedef struct packed {
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic             rd_en;
        logic             mul_en;
        logic             acc_en;
        logic             shift;
        logic             clear;
    } t_cell_ctl;

    typedef struct packed {
        logic             take;
        logic [ROW_W-1:0] idx;
        logic             last;
        logic             bias_we;
        logic [ROW_W-1:0] bias_row;
    } t_post_req;

endpackage

FILE: rtl/fcu_cell.sv
// One MAC cell: weight row memory, multiplier, accumulator and readout shift link.
module fcu_cell #(
    parameter int IN_MAX   = 1024,
    parameter int CELL_IDX = 0,
    parameter int AW       = 10,
    parameter int ACC_W    = 42
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fcu_pkg::t_cell_ctl          i_ctl,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic signed [fcu_pkg::VAL_W-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic signed [fcu_pkg::VAL_W-1:0] i_x,
    input  logic signed [ACC_W-1:0]     i_shift_in,
    output logic signed [ACC_W-1:0]     o_acc
);

    logic signed [fcu_pkg::VAL_W-1:0]  r_mem [IN_MAX];
    logic signed [fcu_pkg::VAL_W-1:0]  r_w;
    logic signed [fcu_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]           r_acc;
    logic                              w_we;

    assign w_we = i_ctl.wr_en && (i_ctl.wr_row == fcu_pkg::ROW_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_w <= r_mem[i_rd_addr];
        end
        if (i_ctl.mul_en) begin
            r_prod <= r_w * i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= i_shift_in;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/fcu_post.sv
// Result path: bias memory, bias add, arithmetic shift, saturation and output register.
module fcu_post #(
    parameter int OUT_MAX = 64,
    parameter int ACC_W   = 42
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fcu_pkg::t_post_req                i_req,
    input  logic signed [fcu_pkg::VAL_W-1:0]  i_bias_data,
    input  logic signed [ACC_W-1:0]           i_acc,
    input  logic [fcu_pkg::FRAC_W-1:0]        i_frac_bits,
    output logic                              o_adv,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fcu_pkg::ROW_W-1:0]         o_out_index,
    output logic signed [fcu_pkg::VAL_W-1:0]  o_out_value,
    output logic                              o_out_last
);

    localparam int BW    = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int MAC_W = ACC_W + 17;
    localparam logic signed [MAC_W-1:0] SAT_HI = MAC_W'(32767);
    localparam logic signed [MAC_W-1:0] SAT_LO = MAC_W'(-32768);

    logic signed [fcu_pkg::VAL_W-1:0] r_bias_mem [OUT_MAX];

    logic                             r_s1_v;
    logic signed [fcu_pkg::VAL_W-1:0] r_s1_bias;
    logic signed [ACC_W-1:0]          r_s1_acc;
    logic [fcu_pkg::ROW_W-1:0]        r_s1_idx;
    logic                             r_s1_last;

    logic                             r_s2_v;
    logic signed [MAC_W-1:0]          r_s2_mac;
    logic [fcu_pkg::ROW_W-1:0]        r_s2_idx;
    logic                             r_s2_last;

    logic                             r_ov;
    logic signed [fcu_pkg::VAL_W-1:0] r_o_value;
    logic [fcu_pkg::ROW_W-1:0]        r_o_idx;
    logic                             r_o_last;

    logic signed [MAC_W-1:0]          w_mac;
    logic signed [MAC_W-1:0]          w_sh;
    logic signed [fcu_pkg::VAL_W-1:0] w_sat;
    logic                             w_bias_we;

    assign o_adv     = !r_ov || i_ready;
    assign w_bias_we = i_req.bias_we && (32'(i_req.bias_row) < OUT_MAX);

    assign w_mac = (MAC_W'(r_s1_bias) <<< i_frac_bits) + MAC_W'(r_s1_acc);
    assign w_sh  = r_s2_mac >>> i_frac_bits;

    always_comb begin
        if (w_sh > SAT_HI) begin
            w_sat = 16'sh7FFF;
        end else if (w_sh < SAT_LO) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_sh[fcu_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bias_we) begin
            r_bias_mem[i_req.bias_row[BW-1:0]] <= i_bias_data;
        end
        if (o_adv) begin
            if (i_req.take) begin
                r_s1_bias <= r_bias_mem[i_req.idx[BW-1:0]];
            end
            r_s1_acc  <= i_acc;
            r_s1_idx  <= i_req.idx;
            r_s1_last <= i_req.last;
            r_s2_mac  <= w_mac;
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
            r_o_value <= w_sat;
            r_o_idx   <= r_s2_idx;
            r_o_last  <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (o_adv) begin
            r_s1_v <= i_req.take;
            r_s2_v <= r_s1_v;
            r_ov   <= r_s2_v;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_index = r_o_idx;
    assign o_out_value = r_o_value;
    assign o_out_last  = r_o_last;

endmodule

FILE: rtl/fixed_point_fully_connected_unit.sv
// Top level of the fixed-point fully connected unit: sequencer, configuration and cell chain.
//
// A row of OUT_MAX MAC cells, one per output neuron, each with its own weight memory of
// IN_MAX entries. Weight loads, bias loads and data elements are taken one per cycle while
// the unit is in its run state; a data element is broadcast to every cell and passes a
// three-stage pipeline (weight memory read, multiply, accumulate). After the element marked
// last, input is held off while that pipeline drains, then the accumulators shift toward
// cell 0 one per cycle while the result path can advance and feed a three-stage result
// path (bias read, bias add, shift and saturate) whose last stage is the output register,
// then a clear state zeroes the accumulators. Input stays held off until that clear, and
// longer when the output side stalls. Weight and bias stores are not cleared by reset.
`include "fixed_point_fully_connected_unit_macros.svh"

module fixed_point_fully_connected_unit #(
    parameter int IN_MAX  = 1024,
    parameter int OUT_MAX = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [fcu_pkg::CMD_W-1:0]             i_command,
    input  logic [fcu_pkg::ROW_W-1:0]             i_row,
    input  logic [fcu_pkg::COL_W-1:0]             i_column,
    input  logic signed [fcu_pkg::VAL_W-1:0]      i_value,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [fcu_pkg::ROW_W-1:0]             o_out_index,
    output logic signed [fcu_pkg::VAL_W-1:0]      o_out_value,
    output logic                                  o_out_last,
    input  logic                                  i_cfg_we,
    input  logic [fcu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fcu_pkg::CFG_DAT_W-1:0]         i_cfg_data
);

    localparam int PW    = $clog2(IN_MAX + 1);
    localparam int AW    = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int CW    = $clog2(OUT_MAX + 1);
    localparam int ACC_W = fcu_pkg::PROD_W + $clog2(IN_MAX);

    localparam logic [1:0] S_RUN   = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_OUT   = 2'd2;
    localparam logic [1:0] S_CLR   = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [PW-1:0]                    r_pos, n_pos;
    logic                             r_v1, n_v1;
    logic                             r_v2;
    logic signed [fcu_pkg::VAL_W-1:0] r_x, n_x;
    logic [CW-1:0]                    r_rem, n_rem;
    logic [fcu_pkg::ROW_W-1:0]        r_idx, n_idx;
    logic [fcu_pkg::OCNT_W-1:0]       r_out_count;
    logic [fcu_pkg::FRAC_W-1:0]       r_frac_bits;

    logic                             w_accept;
    logic                             w_adv;
    logic [CW-1:0]                    w_count;
    fcu_pkg::t_cell_ctl               w_ctl;
    fcu_pkg::t_post_req               w_req;
    logic signed [ACC_W-1:0]          w_acc [OUT_MAX+1];

    assign o_ready  = (r_state == S_RUN);
    assign w_accept = i_valid && o_ready;
    assign w_count  = (32'(r_out_count) > OUT_MAX) ? CW'(OUT_MAX) : CW'(r_out_count);

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_v1           = 1'b0;
        n_x            = r_x;
        n_rem          = r_rem;
        n_idx          = r_idx;
        w_ctl          = '0;
        w_ctl.wr_row   = i_row;
        w_ctl.mul_en   = r_v1;
        w_ctl.acc_en   = r_v2;
        w_req          = '0;
        w_req.idx      = r_idx;
        w_req.bias_row = i_row;
        case (r_state)
            S_RUN: begin
                if (w_accept) begin
                    case (i_command)
                        fcu_pkg::CMD_WEIGHT: begin
                            w_ctl.wr_en = (32'(i_column) < IN_MAX);
                        end
                        fcu_pkg::CMD_BIAS: begin
                            w_req.bias_we = 1'b1;
                        end
                        fcu_pkg::CMD_DATA: begin
                            if (r_pos < PW'(IN_MAX)) begin
                                w_ctl.rd_en = 1'b1;
                                n_v1        = 1'b1;
                                n_x         = i_value;
                                n_pos       = r_pos + PW'(1);
                            end
                            if (i_last) begin
                                n_state = S_DRAIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_OUT;
                    n_rem   = w_count;
                    n_idx   = '0;
                end
            end
            S_OUT: begin
                if (r_rem == '0) begin
                    n_state = S_CLR;
                end else if (w_adv) begin
                    w_ctl.shift = 1'b1;
                    w_req.take  = 1'b1;
                    w_req.last  = (r_rem == CW'(1));
                    n_rem       = r_rem - CW'(1);
                    n_idx       = r_idx + fcu_pkg::ROW_W'(1);
                end
            end
            S_CLR: begin
                w_ctl.clear = 1'b1;
                n_pos       = '0;
                n_state     = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_pos   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_rem   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_v1    <= n_v1;
            r_v2    <= r_v1;
            r_rem   <= n_rem;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_count <= fcu_pkg::OUT_COUNT_RST;
            r_frac_bits <= fcu_pkg::FRAC_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fcu_pkg::REG_OUT_COUNT: r_out_count <= i_cfg_data[fcu_pkg::OCNT_W-1:0];
                fcu_pkg::REG_FRAC_BITS: r_frac_bits <= i_cfg_data[fcu_pkg::FRAC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_acc[OUT_MAX] = '0;

    for (genvar g = 0; g < OUT_MAX; g++) begin : g_cell
        fcu_cell #(
            .IN_MAX   (IN_MAX),
            .CELL_IDX (g),
            .AW       (AW),
            .ACC_W    (ACC_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wr_addr  (AW'(i_column)),
            .i_wr_data  (i_value),
            .i_rd_addr  (r_pos[AW-1:0]),
            .i_x        (r_x),
            .i_shift_in (w_acc[g+1]),
            .o_acc      (w_acc[g])
        );
    end

    fcu_post #(
        .OUT_MAX (OUT_MAX),
        .ACC_W   (ACC_W)
    ) u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_bias_data (i_value),
        .i_acc       (w_acc[0]),
        .i_frac_bits (r_frac_bits),
        .o_adv       (w_adv),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

    `FCU_CHECK(a_pos_bound, r_pos <= PW'(IN_MAX))
    `FCU_CHECK(a_rem_bound, r_rem <= CW'(OUT_MAX))
    `FCU_IMPLY(a_out_drained, r_state == S_OUT, !r_v1 && !r_v2)
    `FCU_NEXT(a_last_drains, w_accept && (i_command == fcu_pkg::CMD_DATA) && i_last, r_state == S_DRAIN)

endmodule

FILE: tb/fc_layer_checker.sv
// Checker for the fully connected unit: watches both channels, predicts layer outputs, compares.
`timescale 1ns / 1ps

module fc_layer_checker #(
    parameter int IN_N  = 1024,
    parameter int OUT_N = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [fcu_pkg::CMD_W-1:0]        i_command,
    input  logic [fcu_pkg::ROW_W-1:0]        i_row,
    input  logic [fcu_pkg::COL_W-1:0]        i_column,
    input  logic signed [fcu_pkg::VAL_W-1:0] i_value,
    input  logic                             i_last,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [fcu_pkg::ROW_W-1:0]        i_out_index,
    input  logic signed [fcu_pkg::VAL_W-1:0] i_out_value,
    input  logic                             i_out_last,
    input  logic                             i_cfg_we,
    input  logic [fcu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fcu_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [fcu_pkg::ROW_W-1:0]        index;
        logic signed [fcu_pkg::VAL_W-1:0] value;
        logic                             last;
    } t_neuron_out;

    shortint     weight_mem [OUT_N][IN_N];
    shortint     bias_mem [OUT_N];
    longint      acc_sum [OUT_N];
    int          elem_pos;
    int unsigned neuron_cnt;
    int unsigned frac_shift;
    t_neuron_out layer_out_q [$];
    t_neuron_out seen;
    t_neuron_out want;

    task automatic add_element(input logic signed [fcu_pkg::VAL_W-1:0] x);
        if (elem_pos < IN_N) begin
            for (int r = 0; r < OUT_N; r++) begin
                acc_sum[r] += longint'(x) * longint'(weight_mem[r][elem_pos]);
            end
            elem_pos++;
        end
    endtask

    task automatic emit_layer_outputs();
        int          cnt;
        longint      mac;
        t_neuron_out res;
        cnt = (neuron_cnt > OUT_N) ? OUT_N : int'(neuron_cnt);
        for (int r = 0; r < cnt; r++) begin
            mac = (longint'(bias_mem[r]) <<< frac_shift) + acc_sum[r];
            mac = mac >>> frac_shift;
            res.index = fcu_pkg::ROW_W'(r);
            if (mac > 32767)
                res.value = 16'sh7fff;
            else if (mac < -32768)
                res.value = 16'sh8000;
            else
                res.value = fcu_pkg::VAL_W'(mac);
            res.last = (r == cnt - 1);
            layer_out_q.push_back(res);
        end
        foreach (acc_sum[r]) acc_sum[r] = 0;
        elem_pos = 0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            neuron_cnt = fcu_pkg::OUT_COUNT_RST;
            frac_shift = fcu_pkg::FRAC_BITS_RST;
            elem_pos = 0;
            foreach (acc_sum[r]) acc_sum[r] = 0;
            layer_out_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen = {i_out_index, i_out_value, i_out_last};
                if (layer_out_q.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result: index %0d value %0d last %0b",
                                 $time, seen.index, seen.value, seen.last);
                    o_fail_count++;
                end else begin
                    want = layer_out_q.pop_front();
                    if (seen.index !== want.index || seen.value !== want.value ||
                        seen.last !== want.last) begin
                        if (o_fail_count < MAX_REPORTS)
                            $display(
                                "%0t: mismatch: expected (%0d, %0d, %0b), actual (%0d, %0d, %0b)",
                                $time, want.index, want.value, want.last,
                                seen.index, seen.value, seen.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == fcu_pkg::REG_OUT_COUNT)
                    neuron_cnt = i_cfg_data[fcu_pkg::OCNT_W-1:0];
                else if (i_cfg_index == fcu_pkg::REG_FRAC_BITS)
                    frac_shift = i_cfg_data[fcu_pkg::FRAC_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                case (i_command)
                    fcu_pkg::CMD_WEIGHT: weight_mem[i_row][i_column] = i_value;
                    fcu_pkg::CMD_BIAS:   bias_mem[i_row] = i_value;
                    fcu_pkg::CMD_DATA: begin
                        add_element(i_value);
                        if (i_last)
                            emit_layer_outputs();
                    end
                    default: ;
                endcase
            end
        end
        o_pending = layer_out_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the fully connected unit testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int IN_N          = 1024;
    localparam int OUT_N         = 64;
    localparam int SETTLE_CYCLES = 80;
    localparam int RX_HOLD       = 600;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PHASE_ITEMS   = 105;
    localparam int CFG_EVERY     = 35;

    localparam logic [fcu_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [fcu_pkg::CMD_W-1:0]        i_command;
    logic [fcu_pkg::ROW_W-1:0]        i_row;
    logic [fcu_pkg::COL_W-1:0]        i_column;
    logic signed [fcu_pkg::VAL_W-1:0] i_value;
    logic                             i_last;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic [fcu_pkg::ROW_W-1:0]        o_out_index;
    logic signed [fcu_pkg::VAL_W-1:0] o_out_value;
    logic                             o_out_last;
    logic                             i_cfg_we;
    logic [fcu_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [fcu_pkg::CFG_DAT_W-1:0]    i_cfg_data;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req_n = 0;
    int hold_ack_n = 0;
    int hold_left = 0;
    int cycles = 0;

    fixed_point_fully_connected_unit #(
        .IN_MAX  (IN_N),
        .OUT_MAX (OUT_N)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_index (o_out_index),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    fc_layer_checker #(
        .IN_N  (IN_N),
        .OUT_N (OUT_N)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_command    (i_command),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_index  (o_out_index),
        .i_out_value  (o_out_value),
        .i_out_last   (o_out_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hold off for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_ack_n != hold_req_n) begin
            hold_ack_n = hold_req_n;
            hold_left = RX_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic logic signed [fcu_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return -16'sh0001;
            default: return fcu_pkg::VAL_W'($urandom);
        endcase
    endfunction

    task automatic offer_item(input logic [fcu_pkg::CMD_W-1:0] cmd,
                              input logic [fcu_pkg::ROW_W-1:0] row,
                              input logic [fcu_pkg::COL_W-1:0] col,
                              input logic signed [fcu_pkg::VAL_W-1:0] val,
                              input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_row     <= row;
        i_column  <= col;
        i_value   <= val;
        i_last    <= last;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    task automatic stream_vector(input int len);
        for (int i = 0; i < len; i++)
            offer_item(fcu_pkg::CMD_DATA, fcu_pkg::ROW_W'($urandom), fcu_pkg::COL_W'($urandom),
                       rand_value(), i == len - 1);
    endtask

    task automatic wait_layer_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_layer_config(input int unsigned n_out, input int unsigned frac);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fcu_pkg::REG_OUT_COUNT;
        i_cfg_data  <= fcu_pkg::CFG_DAT_W'(n_out);
        @(posedge i_clk);
        i_cfg_index <= fcu_pkg::REG_FRAC_BITS;
        i_cfg_data  <= fcu_pkg::CFG_DAT_W'(frac);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_mixed_traffic(input int n_items);
        int sent;
        int next_cfg;
        int kind;
        int len;
        int unsigned n_out;
        sent = 0;
        next_cfg = 0;
        while (sent < n_items) begin
            if (sent >= next_cfg) begin
                wait_layer_idle();
                case ($urandom_range(9))
                    0:       n_out = 0;
                    1:       n_out = $urandom_range(65, 127);
                    2:       n_out = 1;
                    3:       n_out = OUT_N;
                    default: n_out = $urandom_range(1, OUT_N);
                endcase
                set_layer_config(n_out, $urandom_range(31));
                next_cfg += CFG_EVERY;
            end
            kind = $urandom_range(99);
            if (kind < 7) begin
                offer_item(fcu_pkg::CMD_WEIGHT, fcu_pkg::ROW_W'($urandom),
                           fcu_pkg::COL_W'($urandom), rand_value(), 1'($urandom));
                sent++;
            end else if (kind < 11) begin
                offer_item(fcu_pkg::CMD_BIAS, fcu_pkg::ROW_W'($urandom),
                           fcu_pkg::COL_W'($urandom), rand_value(), 1'($urandom));
                sent++;
            end else if (kind < 14) begin
                offer_item(CMD_UNUSED, fcu_pkg::ROW_W'($urandom),
                           fcu_pkg::COL_W'($urandom), rand_value(), 1'($urandom));
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                stream_vector(len);
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = fcu_pkg::CMD_WEIGHT;
        i_row       = '0;
        i_column    = '0;
        i_value     = '0;
        i_last      = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = fcu_pkg::REG_OUT_COUNT;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both stores so no data element reads an unwritten entry
        for (int r = 0; r < OUT_N; r++)
            offer_item(fcu_pkg::CMD_BIAS, fcu_pkg::ROW_W'(r), fcu_pkg::COL_W'($urandom),
                       rand_value(), 1'($urandom));
        for (int r = 0; r < OUT_N; r++)
            for (int c = 0; c < IN_N; c++)
                offer_item(fcu_pkg::CMD_WEIGHT, fcu_pkg::ROW_W'(r), fcu_pkg::COL_W'(c),
                           rand_value(), 1'($urandom));

        offer_item(fcu_pkg::CMD_WEIGHT, 6'd0, 10'd0, 16'sh8000, 1'b0);
        offer_item(fcu_pkg::CMD_WEIGHT, 6'd1, 10'd0, 16'sh7fff, 1'b1);
        offer_item(fcu_pkg::CMD_WEIGHT, 6'd2, 10'd0, -16'sh0001, 1'b0);
        offer_item(fcu_pkg::CMD_BIAS, 6'd0, 10'd1023, 16'sh7fff, 1'b0);
        offer_item(fcu_pkg::CMD_BIAS, 6'd1, 10'd0, 16'sh8000, 1'b0);
        offer_item(fcu_pkg::CMD_BIAS, 6'd2, 10'd0, 16'sh0000, 1'b1);
        offer_item(fcu_pkg::CMD_DATA, 6'd63, 10'd1023, 16'sh8000, 1'b0);
        offer_item(fcu_pkg::CMD_DATA, 6'd0, 10'd0, 16'sh7fff, 1'b1);
        offer_item(CMD_UNUSED, 6'd63, 10'd1023, 16'sh7fff, 1'b1);
        wait_layer_idle();
        set_layer_config(0, 0);
        offer_item(fcu_pkg::CMD_DATA, 6'd21, 10'd682, 16'sh8000, 1'b1);
        wait_layer_idle();
        set_layer_config(127, 31);
        offer_item(fcu_pkg::CMD_DATA, 6'd42, 10'd341, 16'sh7fff, 1'b0);
        offer_item(fcu_pkg::CMD_DATA, 6'd0, 10'd0, 16'sh8000, 1'b1);
        wait_layer_idle();
        set_layer_config(1, 0);
        offer_item(fcu_pkg::CMD_DATA, 6'd0, 10'd0, 16'sh7fff, 1'b0);
        offer_item(fcu_pkg::CMD_DATA, 6'd0, 10'd0, 16'sh7fff, 1'b0);
        offer_item(fcu_pkg::CMD_DATA, 6'd0, 10'd0, 16'sh8000, 1'b1);

        // run past the end of the input range
        wait_layer_idle();
        set_layer_config(OUT_N, 15);
        stream_vector(IN_N + 6);

        // fill the block behind a stalled receiver, then pause until drained
        wait_layer_idle();
        set_layer_config(OUT_N, 4);
        hold_req_n++;
        repeat (4) stream_vector(2);
        wait_layer_idle();

        run_mixed_traffic(PHASE_ITEMS);
        tx_idle_pct = 63;
        rx_stall_pct = 0;
        run_mixed_traffic(PHASE_ITEMS);
        tx_idle_pct = 0;
        rx_stall_pct = 63;
        run_mixed_traffic(PHASE_ITEMS);
        tx_idle_pct = 29;
        rx_stall_pct = 29;
        run_mixed_traffic(PHASE_ITEMS);
        wait_layer_idle();

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
